FILE: rtl/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg
// Opcodes, controller states and the command/status bundles shared by the
// sparse polynomial adder's controller and datapath.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam logic [1:0] OP_LOAD_A = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_MERGE  = 2'd2;

  localparam int COEF_W     = 16;
  localparam int EXPO_W     = 16;
  localparam int OUT_COEF_W = COEF_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_MERGE = 2'b10
  } state_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic [EXPO_W-1:0]        expo;
  } term_t;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic a_has;
    logic b_has;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: rtl/spa_ctrl.sv
// ----------------------------------------------------------------------------
// spa_ctrl
// Controller: decodes input beats into loads and runs the merge sequence.
// ----------------------------------------------------------------------------
module spa_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_opcode,
  output logic             in_ready,
  output spa_pkg::dp_cmd_t cmd,
  input  spa_pkg::dp_sts_t sts
);
  import spa_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_opcode)
            OP_LOAD_A: cmd.load_a = 1'b1;
            OP_LOAD_B: cmd.load_b = 1'b1;
            OP_MERGE:  state_nxt  = ST_MERGE;
            default:   ;
          endcase
        end
      end
      ST_MERGE: begin
        if (sts.out_free) begin
          if (sts.a_has || sts.b_has) begin
            cmd.step = 1'b1;
          end else begin
            cmd.finish = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/spa_dp.sv
// ----------------------------------------------------------------------------
// spa_dp
// Datapath: two term memories, read pointers, merge compare/add, one held
// pending term (so last can be marked) and the output register.
// ----------------------------------------------------------------------------
module spa_dp #(
  parameter int TERMS_PER_LIST = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic signed [spa_pkg::COEF_W-1:0]    in_coef,
  input  logic [spa_pkg::EXPO_W-1:0]           in_expo,
  input  spa_pkg::dp_cmd_t                     cmd,
  output spa_pkg::dp_sts_t                     sts,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic signed [spa_pkg::OUT_COEF_W-1:0] out_coef,
  output logic [spa_pkg::EXPO_W-1:0]           out_expo,
  output logic                                 out_last
);
  import spa_pkg::*;

  localparam int AW = (TERMS_PER_LIST > 1) ? $clog2(TERMS_PER_LIST) : 1;
  localparam int CW = $clog2(TERMS_PER_LIST + 1);
  localparam logic [CW-1:0] DEPTH = CW'(TERMS_PER_LIST);

  term_t mem_a [TERMS_PER_LIST];
  term_t mem_b [TERMS_PER_LIST];
  term_t head_a_r, head_b_r;

  logic [CW-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt;

  logic                         pend_vld_r, pend_vld_nxt;
  logic signed [OUT_COEF_W-1:0] pend_coef_r, pend_coef_nxt;
  logic [EXPO_W-1:0]            pend_expo_r, pend_expo_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic                         out_last_r, out_last_nxt;
  logic signed [OUT_COEF_W-1:0] out_coef_r, out_coef_nxt;
  logic [EXPO_W-1:0]            out_expo_r, out_expo_nxt;

  logic                         a_has, b_has, take_a, take_b, both, produce;
  logic signed [OUT_COEF_W-1:0] ca_ext, cb_ext, sum, new_coef;
  logic [EXPO_W-1:0]            new_expo;
  logic                         wr_a, wr_b;

  assign a_has  = (i_r < cnt_a_r);
  assign b_has  = (j_r < cnt_b_r);
  assign ca_ext = {head_a_r.coef[COEF_W-1], head_a_r.coef};
  assign cb_ext = {head_b_r.coef[COEF_W-1], head_b_r.coef};
  assign sum    = ca_ext + cb_ext;
  assign take_a = a_has && (!b_has || (head_a_r.expo > head_b_r.expo));
  assign take_b = b_has && (!a_has || (head_b_r.expo > head_a_r.expo));
  assign both   = a_has && b_has && (head_a_r.expo == head_b_r.expo);
  assign produce = !(both && (sum == '0));

  always_comb begin
    priority if (take_a) begin
      new_coef = ca_ext;
      new_expo = head_a_r.expo;
    end else if (take_b) begin
      new_coef = cb_ext;
      new_expo = head_b_r.expo;
    end else begin
      new_coef = sum;
      new_expo = head_a_r.expo;
    end
  end

  assign sts.a_has    = a_has;
  assign sts.b_has    = b_has;
  assign sts.out_free = !out_valid_r || out_ready;

  assign wr_a = cmd.load_a && (cnt_a_r < DEPTH);
  assign wr_b = cmd.load_b && (cnt_b_r < DEPTH);

  always_comb begin
    cnt_a_nxt     = cnt_a_r;
    cnt_b_nxt     = cnt_b_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    pend_vld_nxt  = pend_vld_r;
    pend_coef_nxt = pend_coef_r;
    pend_expo_nxt = pend_expo_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_last_nxt  = out_last_r;
    out_coef_nxt  = out_coef_r;
    out_expo_nxt  = out_expo_r;
    if (wr_a) cnt_a_nxt = cnt_a_r + CW'(1);
    if (wr_b) cnt_b_nxt = cnt_b_r + CW'(1);
    if (cmd.step) begin
      if (take_a || both) i_nxt = i_r + CW'(1);
      if (take_b || both) j_nxt = j_r + CW'(1);
      if (produce) begin
        if (pend_vld_r) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b0;
          out_coef_nxt  = pend_coef_r;
          out_expo_nxt  = pend_expo_r;
        end
        pend_vld_nxt  = 1'b1;
        pend_coef_nxt = new_coef;
        pend_expo_nxt = new_expo;
      end
    end
    if (cmd.finish) begin
      // empty result still emits a single zero term
      out_valid_nxt = 1'b1;
      out_last_nxt  = 1'b1;
      out_coef_nxt  = pend_vld_r ? pend_coef_r : '0;
      out_expo_nxt  = pend_vld_r ? pend_expo_r : '0;
      pend_vld_nxt  = 1'b0;
      cnt_a_nxt     = '0;
      cnt_b_nxt     = '0;
      i_nxt         = '0;
      j_nxt         = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_a) mem_a[cnt_a_r[AW-1:0]] <= term_t'{coef: in_coef, expo: in_expo};
    if (wr_b) mem_b[cnt_b_r[AW-1:0]] <= term_t'{coef: in_coef, expo: in_expo};
  end

  // read address follows the next pointer so the head is ready each cycle
  always_ff @(posedge clk) begin
    head_a_r <= mem_a[i_nxt[AW-1:0]];
    head_b_r <= mem_b[j_nxt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      i_r         <= '0;
      j_r         <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_coef_r <= pend_coef_nxt;
    pend_expo_r <= pend_expo_nxt;
    out_last_r  <= out_last_nxt;
    out_coef_r  <= out_coef_nxt;
    out_expo_r  <= out_expo_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_last  = out_last_r;
  assign out_coef  = out_coef_r;
  assign out_expo  = out_expo_r;

`ifndef SYNTHESIS
  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (i_r <= cnt_a_r) && (j_r <= cnt_b_r))
    else $error("read pointer past list count");

  a_finish_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (cnt_a_r == '0) && (cnt_b_r == '0) && !pend_vld_r)
    else $error("lists not emptied after merge");

  a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r && out_last_r)
    else $error("final beat missing last");

  a_step_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step || cmd.finish) |-> (!out_valid_r || out_ready))
    else $error("merge step while output blocked");
`endif

endmodule

FILE: rtl/sparse_polynomial_add_core.sv
// Load beats are taken one per cycle while idle; merge starts the cycle after its beat is taken.
// Merge: one list term consumed per cycle (matched pairs count once) while the output
// is free, then the final beat; output backpressure stalls the merge.
// The first result beat waits until two terms are produced or the merge ends (held term).
// Reset (rst_n low, synchronous) empties both lists; term memories are not cleared.
// ----------------------------------------------------------------------------
// sparse_polynomial_add_core
// Sparse polynomial adder: two term lists merged in descending exponent order.
// ----------------------------------------------------------------------------
module sparse_polynomial_add_core #(
  parameter int TERMS_PER_LIST = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic signed [15:0] in_coef,
  input  logic [15:0]        in_expo,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] out_coef,
  output logic [15:0]        out_expo,
  output logic               out_last
);
  import spa_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  spa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  spa_dp #(
    .TERMS_PER_LIST (TERMS_PER_LIST)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_coef   (in_coef),
    .in_expo   (in_expo),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_coef  (out_coef),
    .out_expo  (out_expo),
    .out_last  (out_last)
  );

endmodule
